// File: hdl/ipv4_header_check_split_macros.svh
// Assertion macros shared by the IPv4 header check block.
`ifndef IPV4_HEADER_CHECK_SPLIT_MACROS_SVH
`define IPV4_HEADER_CHECK_SPLIT_MACROS_SVH

`ifndef SYNTHESIS

// Implication that must hold in the same cycle.
`define IHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ihc check failed: same-cycle implication");

// Implication that must hold in the following cycle.
`define IHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ihc check failed: next-cycle implication");

`else

`define IHC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/ihc_pkg.sv
// Types, constants and helper functions of the IPv4 header check block.
package ihc_pkg;

  localparam int unsigned FIXED_HEADER_BYTES = 20;
  localparam logic [3:0]  MIN_HEADER_WORDS   = 4'd5;

  localparam logic [1:0] REGION_FIXED   = 2'd0;
  localparam logic [1:0] REGION_OPTIONS = 2'd1;
  localparam logic [1:0] REGION_BODY    = 2'd2;

  localparam logic [2:0] STATUS_BUSY        = 3'd0;
  localparam logic [2:0] STATUS_OK          = 3'd1;
  localparam logic [2:0] STATUS_HDR_SHORT   = 3'd2;
  localparam logic [2:0] STATUS_HDR_BEYOND  = 3'd3;
  localparam logic [2:0] STATUS_LEN_MISMATCH = 3'd4;
  localparam logic [2:0] STATUS_BAD_CSUM    = 3'd5;

  typedef struct packed {
    logic [15:0] expected_length;
    logic [3:0]  header_words;
    logic        last_byte;
    logic [7:0]  packet_byte;
  } ihc_item_t;

  typedef struct packed {
    logic [15:0] header_checksum;
    logic [2:0]  check_status;
    logic        packet_done;
    logic [1:0]  byte_region;
    logic [7:0]  data_byte;
  } ihc_result_t;

  // 16-bit ones'-complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

endpackage

// File: hdl/ipv4_header_check_split.sv
// A request is registered in the input stage, then its result in the result stage, which
// holds it until the sink takes it.
// Throughput: one byte per cycle while out_tready is high, set by the single ones'-complement
// adder and compares between the input and result registers.
// Reset (rst_n low, synchronous) empties both stages and zeroes the byte count,
// running sum and held byte, so the next byte starts a new packet.
`include "ipv4_header_check_split_macros.svh"

// Top level of the IPv4 header check block.
module ipv4_header_check_split #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // packet_byte[7:0], header_words[11:8], expected_length[27:12], zero fill.
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // data_byte[7:0], check_status[10:8], header_checksum[26:11], zero fill.
  output logic [31:0] out_tdata,
  // byte_region[1:0].
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  // Input stage: holds one request while the step logic works on it.
  ihc_pkg::ihc_item_t   item_r;
  logic                 item_v_r;
  // Result stage: holds one finished result until the sink takes it.
  ihc_pkg::ihc_result_t res_r;
  logic                 res_v_r;

  // Packet state carried from one byte to the next.
  logic [LENGTH_BITS-1:0] count_r;
  logic [LENGTH_BITS-1:0] count_nxt;
  logic [15:0]            sum_r;
  logic [15:0]            sum_nxt;
  logic [7:0]             hold_r;
  logic [7:0]             hold_nxt;

  ihc_pkg::ihc_result_t   res_nxt;

  logic res_free;
  logic adv;
  logic in_fire;

  // The result register is free when empty or being drained this cycle.
  // The input stage moves forward whenever it has a request and the result
  // register is free, so a new byte is taken every cycle while out_tready is high.
  assign res_free  = !res_v_r || out_tready;
  assign adv       = item_v_r && res_free;
  assign in_tready = !item_v_r || res_free;
  assign in_fire   = in_tvalid && in_tready;

  ihc_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .item      (item_r),
    .count     (count_r),
    .sum       (sum_r),
    .hold      (hold_r),
    .result    (res_nxt),
    .count_nxt (count_nxt),
    .sum_nxt   (sum_nxt),
    .hold_nxt  (hold_nxt)
  );

  // Control state and packet state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      res_v_r  <= 1'b0;
      count_r  <= '0;
      sum_r    <= '0;
      hold_r   <= '0;
    end else begin
      if (in_fire) begin
        item_v_r <= 1'b1;
      end else if (adv) begin
        item_v_r <= 1'b0;
      end
      if (adv) begin
        res_v_r <= 1'b1;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        hold_r  <= hold_nxt;
      end else if (out_tready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.packet_byte     <= in_tdata[7:0];
      item_r.header_words    <= in_tdata[11:8];
      item_r.expected_length <= in_tdata[27:12];
      item_r.last_byte       <= in_tlast;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = {5'd0, res_r.header_checksum, res_r.check_status, res_r.data_byte};
  assign out_tuser  = res_r.byte_region;
  assign out_tlast  = res_r.packet_done;

  // A packet's final byte leaves the counter back at the start.
  `IHC_ASSERT_NEXT(a_count_clears, clk, rst_n, adv && item_r.last_byte, count_r == '0)
  // Body bytes other than a packet's final byte never disturb the running sum.
  `IHC_ASSERT_NEXT(a_body_no_sum, clk, rst_n,
    adv && !item_r.last_byte && (res_nxt.byte_region == ihc_pkg::REGION_BODY),
    $stable(sum_r))
  // Status and checksum are only reported on the final byte.
  `IHC_ASSERT_NOW(a_status_on_done, clk, rst_n, res_v_r && !res_r.packet_done,
    (res_r.check_status == ihc_pkg::STATUS_BUSY) && (res_r.header_checksum == 16'h0000))

endmodule

// File: hdl/ihc_step.sv
// Per-byte header checksum, region tagging and status logic.
module ihc_step #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  ihc_pkg::ihc_item_t   item,
  input  logic [LENGTH_BITS-1:0] count,
  input  logic [15:0]          sum,
  input  logic [7:0]           hold,
  output ihc_pkg::ihc_result_t result,
  output logic [LENGTH_BITS-1:0] count_nxt,
  output logic [15:0]          sum_nxt,
  output logic [7:0]           hold_nxt
);

  logic [5:0]             hlen;
  logic [LENGTH_BITS-1:0] hlen_ext;
  logic [LENGTH_BITS-1:0] fixed_ext;
  logic                   in_hdr;
  logic                   saturated;
  logic                   do_add;
  logic [15:0]            word;
  logic [15:0]            sum_new;
  logic [15:0]            csum;
  logic [16:0]            length_w;

  assign hlen      = {item.header_words, 2'b00};
  assign hlen_ext  = LENGTH_BITS'(hlen);
  assign fixed_ext = LENGTH_BITS'(ihc_pkg::FIXED_HEADER_BYTES);
  assign in_hdr    = count < hlen_ext;
  assign saturated = &count;
  assign length_w  = 17'(count) + 17'd1;

  // An odd position completes a word; a packet ending on an even position
  // sums its lone byte as the high half.
  assign word    = count[0] ? {hold, item.packet_byte} : {item.packet_byte, 8'h00};
  assign do_add  = in_hdr && (count[0] || item.last_byte);
  assign sum_new = do_add ? ihc_pkg::ones_add(sum, word) : sum;
  assign csum    = ~sum_new;

  always_comb begin
    result             = '0;
    result.data_byte   = item.packet_byte;
    result.packet_done = item.last_byte;
    if (!in_hdr) begin
      result.byte_region = ihc_pkg::REGION_BODY;
    end else if (count < fixed_ext) begin
      result.byte_region = ihc_pkg::REGION_FIXED;
    end else begin
      result.byte_region = ihc_pkg::REGION_OPTIONS;
    end

    count_nxt = count;
    sum_nxt   = sum;
    hold_nxt  = hold;

    if (item.last_byte) begin
      result.header_checksum = csum;
      if (item.header_words < ihc_pkg::MIN_HEADER_WORDS) begin
        result.check_status = ihc_pkg::STATUS_HDR_SHORT;
      end else if (!saturated && (17'(hlen) > length_w)) begin
        result.check_status = ihc_pkg::STATUS_HDR_BEYOND;
      end else if (saturated || (length_w != {1'b0, item.expected_length})) begin
        result.check_status = ihc_pkg::STATUS_LEN_MISMATCH;
      end else if (csum != 16'h0000) begin
        result.check_status = ihc_pkg::STATUS_BAD_CSUM;
      end else begin
        result.check_status = ihc_pkg::STATUS_OK;
      end
      count_nxt = '0;
      sum_nxt   = '0;
      hold_nxt  = '0;
    end else begin
      if (in_hdr) begin
        if (count[0]) begin
          sum_nxt = sum_new;
        end else begin
          hold_nxt = item.packet_byte;
        end
      end
      if (!saturated) begin
        count_nxt = count + LENGTH_BITS'(1);
      end
    end
  end

endmodule
